@@ src/voltage_to_wiper_code_inverse_quadratic_defines.svh @@
`ifndef VOLTAGE_TO_WIPER_CODE_INVERSE_QUADRATIC_DEFINES_SVH
`define VOLTAGE_TO_WIPER_CODE_INVERSE_QUADRATIC_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VTWC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VTWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/vtwc_pkg.sv @@
`default_nettype none

package vtwc_pkg;

  localparam int unsigned MvW   = 16;
  localparam int unsigned DW    = 11;
  localparam int unsigned PW    = 24;
  localparam int unsigned RadW  = 50;
  localparam int unsigned RootW = 25;
  localparam int unsigned DivW  = 21;
  localparam int unsigned QuotW = 9;
  localparam int unsigned CodeW = 8;

  localparam logic [MvW-1:0] SplitMv = 16'd6000;
  localparam logic [MvW-1:0] HiMinMv = 16'd11830;
  localparam logic [MvW-1:0] HiMaxMv = 16'd12900;
  localparam logic [MvW-1:0] LoMinMv = 16'd4030;
  localparam logic [MvW-1:0] LoMaxMv = 16'd5300;

  // Curve coefficients scaled by 10^10: a = 6562, b = 22084236.
  localparam logic [DivW-1:0]  CoefA    = 21'd6562;
  localparam logic [RootW-1:0] CoefB    = 25'd22084236;
  localparam logic [PW-1:0]    RadScale = 24'd10000000;
  localparam logic [RadW-1:0]  RadBase  = RadW'(CoefB) * RadW'(CoefB);

  // Division by a as a reciprocal multiplication: for every t below 2^21,
  // floor(t / 6562) equals (t * 5236169) >> 35 exactly.
  localparam int unsigned      RecipW     = 23;
  localparam int unsigned      RecipPW    = DivW + RecipW;
  localparam int unsigned      RecipShift = 35;
  localparam logic [RecipW-1:0] RecipA    = 23'd5236169;

  localparam logic [CodeW-1:0] CodeMax = 8'd255;

  typedef struct packed {
    logic valid;
    logic high;
  } vtwc_ctl_t;

endpackage

`default_nettype wire

@@ src/vtwc_isqrt.sv @@
`default_nettype none

module vtwc_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  vtwc_pkg::vtwc_ctl_t         ctl_i,
  input  logic [vtwc_pkg::RadW-1:0]   rad_i,
  output vtwc_pkg::vtwc_ctl_t         ctl_o,
  output logic [vtwc_pkg::RootW-1:0]  root_o
);
  import vtwc_pkg::*;

  // One root bit per stage, most significant first. The remainder holds
  // the radicand minus the square of the partial root.
  vtwc_ctl_t        ctl_q  [RootW];
  logic [RadW-1:0]  rem_q  [RootW];
  logic [RadW-1:0]  rem_d  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RootW-1:0] root_d [RootW];

  always_comb begin
    logic [RadW-1:0]  rem_src;
    logic [RadW-1:0]  trial;
    logic [RootW-1:0] root_src;
    for (int k = 0; k < RootW; k++) begin
      rem_src  = (k == 0) ? rad_i : rem_q[(k == 0) ? 0 : k - 1];
      root_src = (k == 0) ? '0 : root_q[(k == 0) ? 0 : k - 1];
      trial    = (RadW'(root_src) << (RootW - k)) + (RadW'(1) << (2 * (RootW - 1 - k)));
      if (rem_src >= trial) begin
        rem_d[k]  = rem_src - trial;
        root_d[k] = root_src | (RootW'(1) << (RootW - 1 - k));
      end else begin
        rem_d[k]  = rem_src;
        root_d[k] = root_src;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RootW; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en_i) begin
      for (int k = 0; k < RootW; k++) begin
        ctl_q[k] <= (k == 0) ? ctl_i : ctl_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RootW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign ctl_o  = ctl_q[RootW-1];
  assign root_o = root_q[RootW-1];

endmodule

`default_nettype wire

@@ src/voltage_to_wiper_code_inverse_quadratic.sv @@
// Maps a requested supply voltage in millivolts to a potentiometer wiper code.
// Input channel s_axis carries one item per request: target_mv in tdata.
// Output channel m_axis returns one item per request, in order: wiper_code in
// tdata and the range flag (1 for the 12 V range) in tuser.
// Requests above 6000 mV use the 12 V range, all others the 5 V range; the
// request is clamped to the range and the calibration curve is inverted with
// an exact integer square root followed by a division by the curve's
// quadratic coefficient. The code is truncated and saturated to 255.
// From input acceptance to output valid an item passes through: clamp, two
// multiply stages, 25 square root stages (one root bit each), an offset
// stage, a reciprocal multiply stage for the division and the output register.
// Throughput is one item per cycle while the output is not stalled.
// When the receiver holds m_axis_tready low with a valid output, the whole
// pipeline freezes and s_axis_tready drops until the output is taken.
// Reset clears all valid bits; the datapath registers are not reset.
`default_nettype none

`include "voltage_to_wiper_code_inverse_quadratic_defines.svh"

module voltage_to_wiper_code_inverse_quadratic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [vtwc_pkg::MvW-1:0]     s_axis_tdata,  // [15:0] target_mv
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [vtwc_pkg::CodeW-1:0]   m_axis_tdata,  // [7:0] wiper_code
  output logic                         m_axis_tuser   // [0] high_range
);
  import vtwc_pkg::*;

  logic ce;

  // Clamp stage.
  logic            in_high;
  logic [MvW-1:0]  in_lo;
  logic [MvW-1:0]  in_hi;
  logic [MvW-1:0]  in_v;
  logic [DW-1:0]   s0_d_d;
  vtwc_ctl_t       s0_ctl_q;
  logic [DW-1:0]   s0_d_q;

  // Radicand build: a * d, then times 10^7 plus b squared.
  vtwc_ctl_t       s1_ctl_q;
  logic [PW-1:0]   s1_p_d;
  logic [PW-1:0]   s1_p_q;
  vtwc_ctl_t       s2_ctl_q;
  logic [2*PW-1:0] s2_prod;
  logic [RadW-1:0] s2_rad_d;
  logic [RadW-1:0] s2_rad_q;

  vtwc_ctl_t        sq_ctl;
  logic [RootW-1:0] sq_root;

  vtwc_ctl_t       t_ctl_q;
  logic [DivW-1:0] t_d;
  logic [DivW-1:0] t_q;

  vtwc_ctl_t          q_ctl_q;
  logic [RecipPW-1:0] q_prod;
  logic [QuotW-1:0]   q_d;
  logic [QuotW-1:0]   q_q;

  vtwc_ctl_t        out_ctl_q;
  logic [CodeW-1:0] out_code_d;
  logic [CodeW-1:0] out_code_q;

  assign ce            = m_axis_tready | ~out_ctl_q.valid;
  assign s_axis_tready = ce;

  always_comb begin
    in_high = s_axis_tdata > SplitMv;
    in_lo   = in_high ? HiMinMv : LoMinMv;
    in_hi   = in_high ? HiMaxMv : LoMaxMv;
    if (s_axis_tdata < in_lo) begin
      in_v = in_lo;
    end else if (s_axis_tdata > in_hi) begin
      in_v = in_hi;
    end else begin
      in_v = s_axis_tdata;
    end
    s0_d_d = DW'(in_v - in_lo);
  end

  assign s1_p_d   = PW'(CoefA) * PW'(s0_d_q);
  assign s2_prod  = s1_p_q * RadScale;
  assign s2_rad_d = RadBase + RadW'(s2_prod);

  vtwc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (ce),
    .ctl_i  (s2_ctl_q),
    .rad_i  (s2_rad_q),
    .ctl_o  (sq_ctl),
    .root_o (sq_root)
  );

  // The root never falls below b, since the radicand starts at b squared.
  assign t_d = (sq_root >= CoefB) ? DivW'(sq_root - CoefB) : '0;

  assign q_prod = RecipPW'(t_q) * RecipPW'(RecipA);
  assign q_d    = q_prod[RecipShift +: QuotW];

  assign out_code_d = (q_q >= QuotW'(CodeMax)) ? CodeMax : q_q[CodeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q  <= '0;
      s1_ctl_q  <= '0;
      s2_ctl_q  <= '0;
      t_ctl_q   <= '0;
      q_ctl_q   <= '0;
      out_ctl_q <= '0;
    end else if (ce) begin
      s0_ctl_q.valid <= s_axis_tvalid;
      s0_ctl_q.high  <= in_high;
      s1_ctl_q       <= s0_ctl_q;
      s2_ctl_q       <= s1_ctl_q;
      t_ctl_q        <= sq_ctl;
      q_ctl_q        <= t_ctl_q;
      out_ctl_q      <= q_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s0_d_q     <= s0_d_d;
      s1_p_q     <= s1_p_d;
      s2_rad_q   <= s2_rad_d;
      t_q        <= t_d;
      q_q        <= q_d;
      out_code_q <= out_code_d;
    end
  end

  assign m_axis_tvalid = out_ctl_q.valid;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = out_ctl_q.high;

  `VTWC_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, s0_ctl_q.valid, "accepted item did not enter the pipeline")
  `VTWC_ASSERT_SAME(a_offset_range, s0_ctl_q.valid, s0_d_q <= (s0_ctl_q.high ? DW'(HiMaxMv - HiMinMv) : DW'(LoMaxMv - LoMinMv)), "clamped offset out of range")
  `VTWC_ASSERT_SAME(a_root_floor, sq_ctl.valid, sq_root >= CoefB, "square root below curve offset")
  `VTWC_ASSERT_NEXT(a_stall_freeze, !ce, $stable(s2_ctl_q) && $stable(t_ctl_q) && $stable(out_ctl_q), "pipeline moved during stall")

endmodule

`default_nettype wire
